// ===== rtl/core/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg: shared types, constants and helpers of the line/rectangle clipper
// Widths, edge tables, status codes and the one-bit divider step.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_MAX = 24;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned EXT_W         = COORD_W + 1;     // L+W, T+H
  localparam int unsigned PROD_W        = COORD_W + EXT_W;
  localparam int unsigned CS_W          = COORD_W + FRAC_BITS_MAX;
  // three-term sums; wide enough for every fraction setting in range
  localparam int unsigned SUM_W = ((PROD_W > CS_W) ? PROD_W : CS_W) + 2;
  localparam int unsigned MAG_W = SUM_W - 1;
  localparam int unsigned QUO_W = COORD_W - 1;             // unsaturated quotient
  localparam int unsigned DEN_W = COORD_W;                 // |divisor| <= 2^31

  typedef enum logic [1:0] {ST_OK = 2'd0, ST_MISS = 2'd1, ST_DEGEN = 2'd2} status_e;
  typedef enum logic [1:0] {EDGE_TOP, EDGE_RIGHT, EDGE_BOTTOM, EDGE_LEFT} edge_e;
  typedef enum logic [1:0] {REG_LEFT, REG_TOP, REG_WIDTH, REG_HEIGHT} cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-2:0] width;
    logic [COORD_W-2:0] height;
  } rect_t;

  typedef struct packed {
    logic [3:0]                  code;
    logic [3:0][SUM_W-1:0]       num;   // negated edge numerators, by edge
    logic [COORD_W-1:0]          a;
    logic [COORD_W-1:0]          b;
  } front_t;

  typedef struct packed {
    logic               horiz;  // horizontal edge: coord is v, quotient is u
    logic               neg;
    logic               sat;
    logic [COORD_W-1:0] coord;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] nq;    // dividend bits shift out, quotient bits in
    logic [DEN_W-1:0] den;
    side_t            side;
  } div_lane_t;

  function automatic edge_e edge_first(input logic [3:0] code);
    case (code)
      4'd3, 4'd4, 4'd11, 4'd12: return EDGE_RIGHT;
      4'd7, 4'd8:               return EDGE_BOTTOM;
      default:                  return EDGE_TOP;
    endcase
  endfunction

  function automatic edge_e edge_second(input logic [3:0] code);
    case (code)
      4'd2, 4'd13:                    return EDGE_RIGHT;
      4'd4, 4'd6, 4'd9, 4'd11:        return EDGE_BOTTOM;
      default:                        return EDGE_LEFT;
    endcase
  endfunction

  function automatic logic [EXT_W-1:0] corner_add(input logic [COORD_W-1:0] base,
                                                  input logic [COORD_W-2:0] len);
    return EXT_W'($signed({base[COORD_W-1], base}) + $signed({2'b00, len}));
  endfunction

  function automatic logic [COORD_W-1:0] sat_coord(input logic [EXT_W-1:0] x);
    if (x[EXT_W-1] != x[EXT_W-2]) begin
      return x[EXT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return x[COORD_W-1:0];
  endfunction

  function automatic div_lane_t div_step(input div_lane_t x);
    div_lane_t        y;
    logic [DEN_W:0]   r2;
    logic             ge;
    y  = x;
    r2 = {x.rem, x.nq[QUO_W-1]};
    ge = (r2 >= {1'b0, x.den});
    y.rem = ge ? DEN_W'(r2 - {1'b0, x.den}) : r2[DEN_W-1:0];
    y.nq  = {x.nq[QUO_W-2:0], ge};
    return y;
  endfunction

endpackage

// ===== rtl/core/line_rect_clip.sv =====
// ----------------------------------------------------------------------------
// line_rect_clip: homogeneous line clipping against an axis-aligned rectangle
// Evaluates a*u+b*v+c at the four corners, picks the two crossed edges and
// intersects the line with them; endpoints in saturated signed fixed point.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  line in | start, busy           | line_a_i, line_b_i, line_c_i
//  result  | done_o (strobe)       | p1_u_o, p1_v_o, p2_u_o, p2_v_o, status_o
//  config  | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
//  One transaction enters per clock; busy is never raised. Each result
//  passes through 3 front and 2 select stages, 31 divider stages and one
//  output register: the bit-serial divider, one quotient bit per stage,
//  sets the depth. done_o is high for one cycle per result and cannot be
//  held off. Reset clears valid bits and the rectangle registers; there is
//  nothing to stall.
//
module line_rect_clip #(
  parameter int unsigned COORD_FRAC_BITS = lrc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [lrc_pkg::COORD_W-1:0]  line_a_i,
  input  logic [lrc_pkg::COORD_W-1:0]  line_b_i,
  input  logic [lrc_pkg::COORD_W-1:0]  line_c_i,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [lrc_pkg::COORD_W-1:0]  cfg_wdata_i,
  output logic                         done_o,
  output logic [lrc_pkg::COORD_W-1:0]  p1_u_o,
  output logic [lrc_pkg::COORD_W-1:0]  p1_v_o,
  output logic [lrc_pkg::COORD_W-1:0]  p2_u_o,
  output logic [lrc_pkg::COORD_W-1:0]  p2_v_o,
  output logic [1:0]                   status_o
);
  import lrc_pkg::*;

  localparam int unsigned LATENCY = 5 + QUO_W + 1;

  rect_t              rect_q;
  logic               fr_valid, sel_valid, div_valid, done_q;
  front_t             front;
  status_e            sel_status, div_status;
  div_lane_t [1:0]    sel_lane, div_lane;
  logic [1:0][COORD_W-1:0] quo;
  logic [COORD_W-1:0] p1u_d, p1v_d, p2u_d, p2v_d, p1u_q, p1v_q, p2u_q, p2v_q;
  status_e            status_q;

  // pipeline takes a transaction every cycle
  assign busy = 1'b0;

  // rectangle registers; written by the user only while the pipe is empty (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LEFT:   rect_q.left   <= cfg_wdata_i;
        REG_TOP:    rect_q.top    <= cfg_wdata_i;
        REG_WIDTH:  rect_q.width  <= cfg_wdata_i[COORD_W-2:0];
        REG_HEIGHT: rect_q.height <= cfg_wdata_i[COORD_W-2:0];
        default:    rect_q        <= rect_q;
      endcase
    end
  end

  lrc_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .a_i     (line_a_i),
    .b_i     (line_b_i),
    .c_i     (line_c_i),
    .rect_i  (rect_q),
    .valid_o (fr_valid),
    .front_o (front)
  );

  lrc_select u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (fr_valid),
    .front_i  (front),
    .rect_i   (rect_q),
    .valid_o  (sel_valid),
    .status_o (sel_status),
    .lane_o   (sel_lane)
  );

  lrc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sel_valid),
    .status_i (sel_status),
    .lane_i   (sel_lane),
    .valid_o  (div_valid),
    .status_o (div_status),
    .lane_o   (div_lane)
  );

  // sign and saturation of each quotient, endpoint selection, zero endpoints on a failed clip
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (div_lane[k].side.sat) begin
        quo[k] = div_lane[k].side.neg ? {1'b1, {(COORD_W-1){1'b0}}}
                                      : {1'b0, {(COORD_W-1){1'b1}}};
      end else if (div_lane[k].side.neg) begin
        quo[k] = -{1'b0, div_lane[k].nq};
      end else begin
        quo[k] = {1'b0, div_lane[k].nq};
      end
    end
    p1u_d = div_lane[0].side.horiz ? quo[0] : div_lane[0].side.coord;
    p1v_d = div_lane[0].side.horiz ? div_lane[0].side.coord : quo[0];
    p2u_d = div_lane[1].side.horiz ? quo[1] : div_lane[1].side.coord;
    p2v_d = div_lane[1].side.horiz ? div_lane[1].side.coord : quo[1];
    if (div_status != ST_OK) begin
      p1u_d = '0;
      p1v_d = '0;
      p2u_d = '0;
      p2v_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    p1u_q    <= p1u_d;
    p1v_q    <= p1v_d;
    p2u_q    <= p2u_d;
    p2v_q    <= p2v_d;
    status_q <= div_status;
  end

  assign done_o   = done_q;
  assign p1_u_o   = p1u_q;
  assign p1_v_o   = p1v_q;
  assign p2_u_o   = p2u_q;
  assign p2_v_o   = p2v_q;
  assign status_o = status_q;

`ifndef SYNTHESIS
  // every result stems from a transaction that entered the pipeline
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without matching transaction");

  // a transaction always comes out as a result; none is dropped
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start && !busy, LATENCY) |-> done_o)
    else $error("transaction lost in pipeline");

  // miss and degenerate results carry zero endpoints
  a_zero_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |->
      ((p1_u_o == '0) && (p1_v_o == '0) && (p2_u_o == '0) && (p2_v_o == '0)))
    else $error("nonzero endpoints on failed clip");
`endif

endmodule

// ===== rtl/core/lrc_front.sv =====
// ----------------------------------------------------------------------------
// lrc_front: corner products, corner sign code and edge numerators
// Three register stages: input, products, sums.
// ----------------------------------------------------------------------------
module lrc_front #(
  parameter int unsigned COORD_FRAC_BITS = lrc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [lrc_pkg::COORD_W-1:0]  a_i,
  input  logic [lrc_pkg::COORD_W-1:0]  b_i,
  input  logic [lrc_pkg::COORD_W-1:0]  c_i,
  input  lrc_pkg::rect_t               rect_i,
  output logic                         valid_o,
  output lrc_pkg::front_t              front_o
);
  import lrc_pkg::*;

  logic               v1_q, v2_q, v3_q;
  logic [COORD_W-1:0] a1_q, b1_q, c1_q, a2_q, b2_q;
  logic signed [PROD_W-1:0] pal_q, par_q, pbt_q, pbb_q;
  logic signed [SUM_W-1:0]  cs_q;
  logic [EXT_W-1:0]   xr, yb;
  logic signed [SUM_W-1:0] d0, d1, d2, d3, st, sb, sr, sl;
  front_t             front_d, front_q;

  assign xr = corner_add(rect_i.left, rect_i.width);
  assign yb = corner_add(rect_i.top, rect_i.height);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q  <= a_i;
    b1_q  <= b_i;
    c1_q  <= c_i;
    pal_q <= $signed(a1_q) * $signed({rect_i.left[COORD_W-1], rect_i.left});
    par_q <= $signed(a1_q) * $signed(xr);
    pbt_q <= $signed(b1_q) * $signed({rect_i.top[COORD_W-1], rect_i.top});
    pbb_q <= $signed(b1_q) * $signed(yb);
    cs_q  <= SUM_W'($signed(c1_q)) <<< COORD_FRAC_BITS;
    a2_q  <= a1_q;
    b2_q  <= b1_q;
    front_q <= front_d;
  end

  // partial sums; the top and bottom ones are shared by corner values and edge numerators
  assign st = SUM_W'(pbt_q) + cs_q;
  assign sb = SUM_W'(pbb_q) + cs_q;
  assign sr = SUM_W'(par_q) + cs_q;
  assign sl = SUM_W'(pal_q) + cs_q;
  assign d0 = SUM_W'(pal_q) + st;
  assign d1 = SUM_W'(par_q) + st;
  assign d2 = SUM_W'(par_q) + sb;
  assign d3 = SUM_W'(pal_q) + sb;

  always_comb begin
    front_d.code = {~d3[SUM_W-1], ~d2[SUM_W-1], ~d1[SUM_W-1], ~d0[SUM_W-1]};
    front_d.num[EDGE_TOP]    = -st;
    front_d.num[EDGE_RIGHT]  = -sr;
    front_d.num[EDGE_BOTTOM] = -sb;
    front_d.num[EDGE_LEFT]   = -sl;
    front_d.a = a2_q;
    front_d.b = b2_q;
  end

  assign valid_o = v3_q;
  assign front_o = front_q;

endmodule

// ===== rtl/core/lrc_select.sv =====
// ----------------------------------------------------------------------------
// lrc_select: edge choice, status, operand magnitudes, saturation check
// Two register stages ahead of the divider.
// ----------------------------------------------------------------------------
module lrc_select (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  lrc_pkg::front_t                front_i,
  input  lrc_pkg::rect_t                 rect_i,
  output logic                           valid_o,
  output lrc_pkg::status_e               status_o,
  output lrc_pkg::div_lane_t [1:0]       lane_o
);
  import lrc_pkg::*;

  logic                    v4_q, v5_q;
  status_e                 st_d, st4_q, st5_q;
  logic [1:0][MAG_W-1:0]   nabs_d, nabs_q;
  logic [1:0][DEN_W-1:0]   dabs_d, dabs_q;
  side_t [1:0]             side_d, side_q;
  div_lane_t [1:0]         lane_d, lane_q;
  edge_e [1:0]             edg;
  logic [1:0]              zero_den;
  logic [COORD_W-1:0]      den;
  logic signed [SUM_W-1:0] num;

  assign edg[0] = edge_first(front_i.code);
  assign edg[1] = edge_second(front_i.code);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      side_d[k].horiz = (edg[k] == EDGE_TOP) || (edg[k] == EDGE_BOTTOM);
      den = side_d[k].horiz ? front_i.a : front_i.b;
      num = $signed(front_i.num[edg[k]]);
      zero_den[k] = (den == '0);
      side_d[k].neg = num[SUM_W-1] ^ den[COORD_W-1];
      side_d[k].sat = 1'b0;
      nabs_d[k] = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      dabs_d[k] = den[COORD_W-1] ? DEN_W'(-den) : den;
      case (edg[k])
        EDGE_TOP:    side_d[k].coord = rect_i.top;
        EDGE_RIGHT:  side_d[k].coord = sat_coord(corner_add(rect_i.left, rect_i.width));
        EDGE_BOTTOM: side_d[k].coord = sat_coord(corner_add(rect_i.top, rect_i.height));
        default:     side_d[k].coord = rect_i.left;
      endcase
    end
    if (front_i.code inside {4'd0, 4'd15}) begin
      st_d = ST_MISS;
    end else if (front_i.code inside {4'd5, 4'd10} || (zero_den != 2'b00)) begin
      st_d = ST_DEGEN;
    end else begin
      st_d = ST_OK;
    end
  end

  // quotient saturates exactly when |num| >= |den| * 2^31
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      lane_d[k].side     = side_q[k];
      lane_d[k].side.sat = nabs_q[k] >= MAG_W'({dabs_q[k], {QUO_W{1'b0}}});
      lane_d[k].rem      = DEN_W'(nabs_q[k][MAG_W-1:QUO_W]);
      lane_d[k].nq       = nabs_q[k][QUO_W-1:0];
      lane_d[k].den      = dabs_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st4_q  <= st_d;
    nabs_q <= nabs_d;
    dabs_q <= dabs_d;
    side_q <= side_d;
    st5_q  <= st4_q;
    lane_q <= lane_d;
  end

  assign valid_o  = v5_q;
  assign status_o = st5_q;
  assign lane_o   = lane_q;

endmodule

// ===== rtl/core/lrc_div.sv =====
// ----------------------------------------------------------------------------
// lrc_div: two-lane pipelined restoring divider
// One quotient bit per stage, QUO_W stages, status carried alongside.
// ----------------------------------------------------------------------------
module lrc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  lrc_pkg::status_e           status_i,
  input  lrc_pkg::div_lane_t [1:0]   lane_i,
  output logic                       valid_o,
  output lrc_pkg::status_e           status_o,
  output lrc_pkg::div_lane_t [1:0]   lane_o
);
  import lrc_pkg::*;

  logic            valid_q  [QUO_W];
  status_e         status_q [QUO_W];
  div_lane_t [1:0] lane_q   [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic            v_in;
    status_e         st_in;
    div_lane_t [1:0] l_in;
    if (s == 0) begin : g_head
      assign v_in  = valid_i;
      assign st_in = status_i;
      assign l_in  = lane_i;
    end else begin : g_body
      assign v_in  = valid_q[s-1];
      assign st_in = status_q[s-1];
      assign l_in  = lane_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      status_q[s]  <= st_in;
      lane_q[s][0] <= div_step(l_in[0]);
      lane_q[s][1] <= div_step(l_in[1]);
    end
  end

  assign valid_o  = valid_q[QUO_W-1];
  assign status_o = status_q[QUO_W-1];
  assign lane_o   = lane_q[QUO_W-1];

endmodule

// ===== verif/tb_line_rect_clip.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_rect_clip: self-checking bench for the line/rectangle clipper
// Drives line transactions, with random gaps in most phases, predicts each clipped segment
// with exact wide arithmetic and compares every done_o strobe in order.
// ----------------------------------------------------------------------------

class clip_scoreboard;
  localparam int FRAC = 16;

  typedef struct {
    logic [31:0]      p1_u, p1_v, p2_u, p2_v;
    lrc_pkg::status_e status;
  } segment_t;

  // rectangle copy, kept as wide signed values
  longint left, top, width, height;
  segment_t pending[$];
  int unsigned errors;

  function void set_reg(lrc_pkg::cfg_reg_e idx, logic [31:0] val);
    case (idx)
      lrc_pkg::REG_LEFT:   left   = longint'($signed(val));
      lrc_pkg::REG_TOP:    top    = longint'($signed(val));
      lrc_pkg::REG_WIDTH:  width  = longint'(val[30:0]);
      lrc_pkg::REG_HEIGHT: height = longint'(val[30:0]);
      default: ;
    endcase
  endfunction

  function logic [31:0] sat32(logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'h7fff_ffff;
    if (x < -128'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // truncating division, then saturation
  function logic [31:0] quotient(logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] q;
    logic [127:0] mn, md;
    mn = num[127] ? -num : num;
    md = den[127] ? -den : den;
    q  = $signed(mn / md);
    if (num[127] != den[127]) q = -q;
    return sat32(q);
  endfunction

  // returns 0 on a zero divisor
  function bit cut(lrc_pkg::edge_e e, logic signed [127:0] a, b, cs,
                   output logic [31:0] pu, pv);
    logic signed [127:0] k;
    if (e == lrc_pkg::EDGE_TOP || e == lrc_pkg::EDGE_BOTTOM) begin
      k = (e == lrc_pkg::EDGE_TOP) ? top : top + height;
      if (a == 0) return 0;
      pv = sat32(k);
      pu = quotient(-(b * k + cs), a);
    end else begin
      k = (e == lrc_pkg::EDGE_RIGHT) ? left + width : left;
      if (b == 0) return 0;
      pu = sat32(k);
      pv = quotient(-(a * k + cs), b);
    end
    return 1;
  endfunction

  function void note_line(logic [31:0] la, lb, lc);
    logic signed [127:0] a, b, cs, d;
    logic signed [127:0] cu[4], cv[4];
    logic [3:0] code;
    segment_t s;
    lrc_pkg::edge_e e1, e2;
    a  = $signed(la);
    b  = $signed(lb);
    cs = $signed(lc) * (128'sd1 <<< FRAC);
    cu[0] = left;         cv[0] = top;
    cu[1] = left + width; cv[1] = top;
    cu[2] = left + width; cv[2] = top + height;
    cu[3] = left;         cv[3] = top + height;
    for (int i = 0; i < 4; i++) begin
      d = cu[i] * a + cv[i] * b + cs;
      code[i] = (d >= 0);
    end
    s = '{0, 0, 0, 0, lrc_pkg::ST_OK};
    // crossed edges per sign code
    case (code)
      4'd3, 4'd4, 4'd11, 4'd12: e1 = lrc_pkg::EDGE_RIGHT;
      4'd7, 4'd8:               e1 = lrc_pkg::EDGE_BOTTOM;
      default:                  e1 = lrc_pkg::EDGE_TOP;
    endcase
    case (code)
      4'd2, 4'd13:             e2 = lrc_pkg::EDGE_RIGHT;
      4'd4, 4'd6, 4'd9, 4'd11: e2 = lrc_pkg::EDGE_BOTTOM;
      default:                 e2 = lrc_pkg::EDGE_LEFT;
    endcase
    if (code == 4'd0 || code == 4'd15) s.status = lrc_pkg::ST_MISS;
    else if (code == 4'd5 || code == 4'd10) s.status = lrc_pkg::ST_DEGEN;
    else if (!cut(e1, a, b, cs, s.p1_u, s.p1_v) || !cut(e2, a, b, cs, s.p2_u, s.p2_v))
      s.status = lrc_pkg::ST_DEGEN;
    if (s.status != lrc_pkg::ST_OK) begin
      s.p1_u = 0; s.p1_v = 0; s.p2_u = 0; s.p2_v = 0;
    end
    pending.push_back(s);
  endfunction

  function void check_segment(logic [31:0] p1u, p1v, p2u, p2v, logic [1:0] st);
    segment_t s;
    if (pending.size() == 0) begin
      $error("result with no transaction outstanding");
      errors++;
      return;
    end
    s = pending.pop_front();
    if (p1u !== s.p1_u) begin $error("p1_u exp %h got %h", s.p1_u, p1u); errors++; end
    if (p1v !== s.p1_v) begin $error("p1_v exp %h got %h", s.p1_v, p1v); errors++; end
    if (p2u !== s.p2_u) begin $error("p2_u exp %h got %h", s.p2_u, p2u); errors++; end
    if (p2v !== s.p2_v) begin $error("p2_v exp %h got %h", s.p2_v, p2v); errors++; end
    if (st !== s.status) begin $error("status exp %0d got %0d", s.status, st); errors++; end
  endfunction
endclass

module tb_line_rect_clip;
  import lrc_pkg::*;

  localparam int LATENCY = 37;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] line_a_i = '0, line_b_i = '0, line_c_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [31:0] p1_u_o, p1_v_o, p2_u_o, p2_v_o;
  logic [1:0]  status_o;

  clip_scoreboard clip_sb = new();
  bit quiet_run;  // no random gaps while set

  line_rect_clip u_dut (.*);

  initial forever #10 clk_i = ~clk_i;

  // results are sampled on the rising edge that ends the strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) clip_sb.check_segment(p1_u_o, p1_v_o, p2_u_o, p2_v_o, status_o);
  end

  // config writes only with the pipe drained; the caller drops cfg_we_i
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    clip_sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic set_rect(logic [31:0] l, t, w, h);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_WIDTH, {1'b0, w[30:0]});
    write_reg(REG_HEIGHT, {1'b0, h[30:0]});
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (clip_sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // one line transaction; start stays high across back-to-back sends
  task automatic send_line(logic [31:0] a, b, c);
    if (!quiet_run) begin
      while ($urandom_range(99) < 25) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start    <= 1'b1;
    line_a_i <= a;
    line_b_i <= b;
    line_c_i <= c;
    do @(posedge clk_i); while (busy);
    clip_sb.note_line(a, b, c);
    @(negedge clk_i);
  endtask

  task automatic idle_start();
    start <= 1'b0;
    @(negedge clk_i);
  endtask

  // random word, often a special value: most negative, most positive, zero or a shifted byte
  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(8'hff) << $urandom_range(16);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_lines(int n, logic [31:0] l, t, w, h);
    logic signed [63:0] pu, pv, a, b, c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70) begin
        a  = $signed(32'($urandom_range(16'hffff)) - 32'h8000);
        b  = $signed(32'($urandom_range(16'hffff)) - 32'h8000);
        pu = 64'($signed(l)) + 64'(w[30:0] == 0 ? 0 : $urandom_range(w[30:0]));
        pv = 64'($signed(t)) + 64'(h[30:0] == 0 ? 0 : $urandom_range(h[30:0]));
        c  = -(a * pu + b * pv) >>> 16;
        send_line(a[31:0], b[31:0], c[31:0]);
      end else begin
        send_line(rnd_word(), rnd_word(), rnd_word());
      end
    end
    idle_start();
  endtask

  initial begin
    logic [31:0] l, t, w, h;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: unit square at origin (Q16.16)
    set_rect(32'h0, 32'h0, 32'h1_0000, 32'h1_0000);
    quiet_run = 1'b1;
    send_line(32'h1_0000, 32'h0, 32'hffff_8000);  // vertical u=0.5, b=0, cuts top and bottom
    send_line(32'h0, 32'h1_0000, 32'hffff_8000);  // horizontal v=0.5, a=0, cuts right and left
    send_line(32'h1_0000, 32'h1_0000, 32'hffff_0000);  // diagonal through corners
    send_line(32'h1_0000, 32'hffff_0000, 32'h0);  // main diagonal
    send_line(32'h1_0000, 32'h1_0000, 32'h0_8000);  // miss, all positive
    send_line(32'h1_0000, 32'h1_0000, 32'hfffc_0000);  // miss, all negative
    send_line(32'h1_0000, 32'h2_0000, 32'hffff_0000);  // ok, crosses top and left edges
    send_line(32'h0, 32'h0, 32'h0);  // all zero: code 15
    send_line(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_line(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_line(32'h1, 32'hffff_ffff, 32'h0);
    send_line(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
    idle_start();
    drain();
    // extreme rectangle at the most negative corner: code 5 / 10 tries
    set_rect(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_line(32'h1, 32'h7fff_ffff, 32'h0);
    send_line(32'h7fff_ffff, 32'h1, 32'h0);
    send_line(32'h1_0000, 32'hffff_0000, 32'h1234);
    send_line(32'h1, 32'h1, 32'h0);
    send_line(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    idle_start();
    drain();
    set_rect(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_line(32'h1, 32'hffff_ffff, 32'h0);
    send_line(32'h1_0000, 32'h2_0000, 32'h8000_0000);
    idle_start();
    drain();

    // random phases; the first runs without gaps
    for (int ph = 0; ph < 8; ph++) begin
      quiet_run = (ph == 0);
      l = (ph == 7) ? 32'h8000_0000 : rnd_word();
      t = (ph == 7) ? 32'h7fff_ffff : rnd_word();
      w = (ph == 6) ? 32'h0 : {1'b0, rnd_word()} >> $urandom_range(15);
      h = (ph == 6) ? 32'h7fff_ffff : {1'b0, rnd_word()} >> $urandom_range(15);
      set_rect(l, t, w, h);
      random_lines(250, l, t, w, h);
      drain();
    end

    repeat (LATENCY + 5) @(negedge clk_i);
    if (clip_sb.errors == 0 && clip_sb.pending.size() == 0) $display("tb_line_rect_clip: clean");
    else $display("tb_line_rect_clip: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_line_rect_clip: errors");
    $finish;
  end
endmodule
